// ===== rtl/nearest_timestamp_matcher_top_assert.svh =====
// Assertion helpers; expect clk and arst_n in the including module.
`ifndef NEAREST_TIMESTAMP_MATCHER_TOP_ASSERT_SVH
`define NEAREST_TIMESTAMP_MATCHER_TOP_ASSERT_SVH

// same-cycle implication
`define NTM_CHK_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define NTM_CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ntm_pkg.sv =====
package ntm_pkg;

	localparam int TABLE_DEPTH_DEF = 4096;
	localparam int TIME_BITS_DEF   = 48;

	localparam int DIFF_BITS  = 24;
	localparam int INDEX_BITS = 12;
	localparam int COUNT_BITS = 32;
	localparam int ADDR_BITS  = 3;
	localparam int DATA_BITS  = 32;

	localparam logic [DIFF_BITS-1:0] DIFF_LIMIT_RST   = 24'd10000;
	localparam logic                 LIMIT_ENABLE_RST = 1'b1;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_BEGIN  = 2'd2,
		CMD_QUERY  = 2'd3
	} cmd_t;

	typedef enum logic {
		REG_DIFF_LIMIT   = 1'b0,
		REG_LIMIT_ENABLE = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [DIFF_BITS-1:0] diff_limit;
		logic                 limit_enable;
	} cfg_t;

endpackage

// ===== rtl/ntm_ram.sv =====
module ntm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/ntm_apb.sv =====
module ntm_apb (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ntm_pkg::ADDR_BITS-1:0]  paddr,
	input  logic [ntm_pkg::DATA_BITS-1:0]  pwdata,
	output logic [ntm_pkg::DATA_BITS-1:0]  prdata,
	output logic                           pready,
	output ntm_pkg::cfg_t                  cfg
);

	ntm_pkg::cfg_t     cfg_q;
	ntm_pkg::reg_idx_t reg_sel;
	logic              wr_en;

	assign pready  = 1'b1;
	assign reg_sel = ntm_pkg::reg_idx_t'(paddr[2]);
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.diff_limit   <= ntm_pkg::DIFF_LIMIT_RST;
			cfg_q.limit_enable <= ntm_pkg::LIMIT_ENABLE_RST;
		end else if (wr_en) begin
			case (reg_sel)
				ntm_pkg::REG_DIFF_LIMIT: begin
					cfg_q.diff_limit <= pwdata[ntm_pkg::DIFF_BITS-1:0];
				end
				ntm_pkg::REG_LIMIT_ENABLE: begin
					cfg_q.limit_enable <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			ntm_pkg::REG_DIFF_LIMIT:   prdata = ntm_pkg::DATA_BITS'(cfg_q.diff_limit);
			ntm_pkg::REG_LIMIT_ENABLE: prdata = ntm_pkg::DATA_BITS'(cfg_q.limit_enable);
			default:                   prdata = '0;
		endcase
	end

endmodule

// ===== rtl/ntm_ctrl.sv =====
`include "nearest_timestamp_matcher_top_assert.svh"

module ntm_ctrl #(
	parameter int TABLE_DEPTH = ntm_pkg::TABLE_DEPTH_DEF,
	parameter int TIME_BITS   = ntm_pkg::TIME_BITS_DEF,
	localparam int IDX_W = $clog2(TABLE_DEPTH),
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ntm_pkg::cfg_t                   cfg,
	input  logic                            cmd_valid,
	output logic                            cmd_stall,
	input  logic [1:0]                      command,
	input  logic [TIME_BITS-1:0]            time_us,
	input  logic                            time_present,
	output logic                            res_valid,
	input  logic                            res_stall,
	output logic                            match_found,
	output logic [ntm_pkg::INDEX_BITS-1:0]  match_index,
	output logic [ntm_pkg::COUNT_BITS-1:0]  matched_total,
	output logic                            ram_we,
	output logic [IDX_W-1:0]                ram_waddr,
	output logic [TIME_BITS:0]              ram_wdata,
	output logic                            ram_re,
	output logic [IDX_W-1:0]                ram_raddr,
	input  logic [TIME_BITS:0]              ram_rdata
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FIN
	} state_t;

	state_t                          state_q;
	logic [CNT_W-1:0]                entry_count_q;
	logic [CNT_W-1:0]                rd_ptr_q;
	logic [IDX_W-1:0]                search_start_q;
	logic [IDX_W-1:0]                idx_s1;
	logic [IDX_W-1:0]                idx_s2;
	logic [IDX_W-1:0]                best_q;
	logic                            v_s1;
	logic                            v_s2;
	logic                            pres_s2;
	logic                            have_q;
	logic [TIME_BITS-1:0]            qtime_q;
	logic [TIME_BITS-1:0]            dist_s2;
	logic [TIME_BITS-1:0]            best_dist_q;
	logic [ntm_pkg::COUNT_BITS-1:0]  match_count_q;
	logic                            res_valid_q;
	logic                            match_found_q;
	logic [ntm_pkg::INDEX_BITS-1:0]  match_index_q;
	logic [ntm_pkg::COUNT_BITS-1:0]  matched_total_q;

	ntm_pkg::cmd_t                   cmd_e;
	logic                            cmd_fire;
	logic [TIME_BITS-1:0]            ram_t;
	logic                            ram_pres;
	logic                            borrow;
	logic [TIME_BITS-1:0]            diff_fwd;
	logic [TIME_BITS-1:0]            diff_rev;
	logic [TIME_BITS-1:0]            dist_s1;
	logic                            better;
	logic                            take;
	logic                            stop;
	logic                            issue;
	logic                            start_ok;
	logic                            limit_hit;
	logic                            found;
	logic                            res_free;
	logic [ntm_pkg::COUNT_BITS-1:0]  count_next;
	logic [63:0]                     best_wide;

	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_fire  = cmd_valid && !cmd_stall;
	assign cmd_e     = ntm_pkg::cmd_t'(command);

	assign ram_t    = ram_rdata[TIME_BITS-1:0];
	assign ram_pres = ram_rdata[TIME_BITS];

	// both directions in parallel, borrow picks the positive one
	assign {borrow, diff_fwd} = {1'b0, ram_t} - {1'b0, qtime_q};
	assign diff_rev = qtime_q - ram_t;
	assign dist_s1  = borrow ? diff_rev : diff_fwd;

	assign better = !have_q || (dist_s2 < best_dist_q);
	assign take   = v_s2 && pres_s2 && better;
	assign stop   = v_s2 && pres_s2 && !better;

	assign issue    = (rd_ptr_q < entry_count_q);
	assign start_ok = (CNT_W'(search_start_q) < entry_count_q);

	assign limit_hit  = cfg.limit_enable && (best_dist_q > TIME_BITS'(cfg.diff_limit));
	assign found      = have_q && !limit_hit;
	assign res_free   = !res_valid_q || !res_stall;
	assign count_next = (found && (match_count_q != '1)) ?
		match_count_q + ntm_pkg::COUNT_BITS'(1) : match_count_q;
	assign best_wide  = 64'(best_q);

	assign ram_we    = cmd_fire && (cmd_e == ntm_pkg::CMD_APPEND) &&
		(entry_count_q != CNT_W'(TABLE_DEPTH));
	assign ram_waddr = entry_count_q[IDX_W-1:0];
	assign ram_wdata = {time_present, time_us};

	always_comb begin
		case (state_q)
			ST_IDLE: begin
				ram_re    = cmd_fire && (cmd_e == ntm_pkg::CMD_QUERY) && start_ok;
				ram_raddr = search_start_q;
			end
			ST_WALK: begin
				ram_re    = !stop && issue;
				ram_raddr = rd_ptr_q[IDX_W-1:0];
			end
			default: begin
				ram_re    = 1'b0;
				ram_raddr = rd_ptr_q[IDX_W-1:0];
			end
		endcase
	end

	assign res_valid     = res_valid_q;
	assign match_found   = match_found_q;
	assign match_index   = match_index_q;
	assign matched_total = matched_total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			entry_count_q   <= '0;
			rd_ptr_q        <= '0;
			search_start_q  <= '0;
			idx_s1          <= '0;
			idx_s2          <= '0;
			best_q          <= '0;
			v_s1            <= 1'b0;
			v_s2            <= 1'b0;
			pres_s2         <= 1'b0;
			have_q          <= 1'b0;
			qtime_q         <= '0;
			dist_s2         <= '0;
			best_dist_q     <= '0;
			match_count_q   <= '0;
			res_valid_q     <= 1'b0;
			match_found_q   <= 1'b0;
			match_index_q   <= '0;
			matched_total_q <= '0;
		end else begin
			// in ST_FIN the result register is reloaded below
			if (res_valid_q && !res_stall && (state_q != ST_FIN)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						case (cmd_e)
							ntm_pkg::CMD_CLEAR: begin
								entry_count_q  <= '0;
								search_start_q <= '0;
							end
							ntm_pkg::CMD_APPEND: begin
								if (ram_we) begin
									entry_count_q <= entry_count_q + CNT_W'(1);
								end
							end
							ntm_pkg::CMD_BEGIN: begin
								search_start_q <= '0;
								match_count_q  <= '0;
							end
							ntm_pkg::CMD_QUERY: begin
								qtime_q  <= time_us;
								have_q   <= 1'b0;
								v_s1     <= start_ok;
								idx_s1   <= search_start_q;
								v_s2     <= 1'b0;
								rd_ptr_q <= CNT_W'(search_start_q) + (start_ok ? CNT_W'(1) : '0);
								state_q  <= ST_WALK;
							end
							default: begin
							end
						endcase
					end
				end
				ST_WALK: begin
					if (stop) begin
						// first present entry that does not get closer ends the walk
						v_s1    <= 1'b0;
						v_s2    <= 1'b0;
						state_q <= ST_FIN;
					end else begin
						if (take) begin
							have_q      <= 1'b1;
							best_q      <= idx_s2;
							best_dist_q <= dist_s2;
						end
						v_s1   <= issue;
						idx_s1 <= rd_ptr_q[IDX_W-1:0];
						if (issue) begin
							rd_ptr_q <= rd_ptr_q + CNT_W'(1);
						end
						v_s2    <= v_s1;
						idx_s2  <= idx_s1;
						pres_s2 <= ram_pres;
						dist_s2 <= dist_s1;
						if (!issue && !v_s1) begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (res_free) begin
						res_valid_q     <= 1'b1;
						match_found_q   <= found;
						match_index_q   <= found ? best_wide[ntm_pkg::INDEX_BITS-1:0] : '0;
						matched_total_q <= count_next;
						match_count_q   <= count_next;
						if (found) begin
							search_start_q <= best_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`NTM_CHK_IMPL(a_ptr_in_table, state_q == ST_WALK, rd_ptr_q <= entry_count_q, "read pointer past table fill")
	`NTM_CHK_IMPL(a_walk_forward, state_q == ST_WALK && v_s2, idx_s2 >= search_start_q, "walk went behind start index")
	`NTM_CHK_IMPL(a_match_in_table, state_q == ST_FIN && res_free && found, CNT_W'(best_q) < entry_count_q, "match outside table")
	`NTM_CHK_NEXT(a_count_nonzero, state_q == ST_FIN && res_free && found, match_count_q != '0, "match not counted")

endmodule

// ===== rtl/nearest_timestamp_matcher_top.sv =====
// Nearest timestamp matcher: table of reference times in one RAM, walked per query.
// Clear, append and begin-pass transfers are accepted back to back.
// A query walks from its start index to the stop entry or table end through the RAM read,
// distance and compare registers, then loads the result register (later while an older result is
// stalled); the next command is taken after that. At most one read past the stop is discarded.
// arst_n clears fill count, start index, match count and config to defaults; RAM is not cleared.
module nearest_timestamp_matcher_top #(
	parameter int TABLE_DEPTH = ntm_pkg::TABLE_DEPTH_DEF,
	parameter int TIME_BITS   = ntm_pkg::TIME_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ntm_pkg::ADDR_BITS-1:0]   paddr,
	input  logic [ntm_pkg::DATA_BITS-1:0]   pwdata,
	output logic [ntm_pkg::DATA_BITS-1:0]   prdata,
	output logic                            pready,
	input  logic                            cmd_valid,
	output logic                            cmd_stall,
	input  logic [1:0]                      command,
	input  logic [TIME_BITS-1:0]            time_us,
	input  logic                            time_present,
	output logic                            res_valid,
	input  logic                            res_stall,
	output logic                            match_found,
	output logic [ntm_pkg::INDEX_BITS-1:0]  match_index,
	output logic [ntm_pkg::COUNT_BITS-1:0]  matched_total
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);

	ntm_pkg::cfg_t       cfg;
	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	logic [TIME_BITS:0]  ram_wdata;
	logic                ram_re;
	logic [IDX_W-1:0]    ram_raddr;
	logic [TIME_BITS:0]  ram_rdata;

	ntm_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// entry word: present flag above the timestamp
	ntm_ram #(
		.WIDTH (TIME_BITS + 1),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ntm_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.TIME_BITS   (TIME_BITS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd_valid     (cmd_valid),
		.cmd_stall     (cmd_stall),
		.command       (command),
		.time_us       (time_us),
		.time_present  (time_present),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.match_found   (match_found),
		.match_index   (match_index),
		.matched_total (matched_total),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_wdata     (ram_wdata),
		.ram_re        (ram_re),
		.ram_raddr     (ram_raddr),
		.ram_rdata     (ram_rdata)
	);

endmodule

// ===== bench/nearest_timestamp_matcher_top_test.sv =====
module nearest_timestamp_matcher_top_test;

	localparam int TB_DEPTH     = ntm_pkg::TABLE_DEPTH_DEF;
	localparam int TB_TIME_BITS = ntm_pkg::TIME_BITS_DEF;
	localparam int ADDR_W       = ntm_pkg::ADDR_BITS;
	localparam int DATA_W       = ntm_pkg::DATA_BITS;
	localparam int INDEX_W      = ntm_pkg::INDEX_BITS;
	localparam int COUNT_W      = ntm_pkg::COUNT_BITS;
	localparam int DIFF_W       = ntm_pkg::DIFF_BITS;
	localparam logic [TB_TIME_BITS-1:0] TIME_TOP = '1;
	localparam logic [ADDR_W-1:0] ADDR_DIFF     = ADDR_W'({ntm_pkg::REG_DIFF_LIMIT, 2'b00});
	localparam logic [ADDR_W-1:0] ADDR_LIMIT_EN = ADDR_W'({ntm_pkg::REG_LIMIT_ENABLE, 2'b00});

	typedef struct packed {
		logic               found;
		logic [INDEX_W-1:0] index;
		logic [COUNT_W-1:0] total;
	} match_answer_t;

	// Mirror of the matcher: table, walk start, pass count and limit settings.
	class nearest_match_tracker;
		logic [TB_TIME_BITS-1:0] entry_time [TB_DEPTH];
		bit                      entry_here [TB_DEPTH];
		int unsigned             fill;
		int unsigned             walk_from;
		logic [COUNT_W-1:0]      hits;
		logic [DIFF_W-1:0]       reach;
		bit                      reach_on;
		match_answer_t           awaited [$];
		int                      errors;

		function new();
			fill = 0;
			walk_from = 0;
			hits = '0;
			reach = ntm_pkg::DIFF_LIMIT_RST;
			reach_on = ntm_pkg::LIMIT_ENABLE_RST;
			errors = 0;
		endfunction

		function void take_limits(logic [DIFF_W-1:0] d, logic en);
			reach = d;
			reach_on = en;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void note_command(ntm_pkg::cmd_t c, logic [TB_TIME_BITS-1:0] t, logic p);
			bit have;
			int unsigned best;
			int unsigned i;
			logic [TB_TIME_BITS-1:0] gap_now;
			logic [TB_TIME_BITS-1:0] gap_best;
			match_answer_t ans;
			have = 0;
			best = 0;
			gap_best = '0;
			case (c)
				ntm_pkg::CMD_CLEAR: begin
					fill = 0;
					walk_from = 0;
				end
				ntm_pkg::CMD_APPEND: begin
					if (fill < TB_DEPTH) begin
						entry_time[fill] = t;
						entry_here[fill] = p;
						fill++;
					end
				end
				ntm_pkg::CMD_BEGIN: begin
					walk_from = 0;
					hits = '0;
				end
				default: begin
					// stop at the first present entry that does not get strictly closer
					for (i = walk_from; i < fill; i++) begin
						if (!entry_here[i])
							continue;
						gap_now = (entry_time[i] > t) ? entry_time[i] - t : t - entry_time[i];
						if (have && gap_now >= gap_best)
							break;
						have = 1;
						best = i;
						gap_best = gap_now;
					end
					ans.found = have && !(reach_on && gap_best > TB_TIME_BITS'(reach));
					ans.index = ans.found ? INDEX_W'(best) : '0;
					if (ans.found) begin
						walk_from = best;
						if (hits != '1)
							hits++;
					end
					ans.total = hits;
					awaited.insert(awaited.size(), ans);
				end
			endcase
		endfunction

		function void check_answer(logic f, logic [INDEX_W-1:0] idx,
			logic [COUNT_W-1:0] tot);
			match_answer_t exp_ans;
			if (awaited.size() == 0) begin
				$display("%0t: result with none pending: found %0b index %0d total %0d",
					$time, f, idx, tot);
				errors++;
				return;
			end
			exp_ans = awaited.pop_front();
			if (f !== exp_ans.found) begin
				$display("%0t: match_found expected %0b actual %0b", $time, exp_ans.found, f);
				errors++;
			end
			if (idx !== exp_ans.index) begin
				$display("%0t: match_index expected %0d actual %0d", $time, exp_ans.index, idx);
				errors++;
			end
			if (tot !== exp_ans.total) begin
				$display("%0t: matched_total expected %0d actual %0d", $time, exp_ans.total, tot);
				errors++;
			end
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [ADDR_W-1:0]       paddr;
	logic [DATA_W-1:0]       pwdata;
	logic [DATA_W-1:0]       prdata;
	logic                    pready;
	logic                    cmd_valid;
	logic                    cmd_stall;
	logic [1:0]              command;
	logic [TB_TIME_BITS-1:0] time_us;
	logic                    time_present;
	logic                    res_valid;
	logic                    res_stall;
	logic                    match_found;
	logic [INDEX_W-1:0]      match_index;
	logic [COUNT_W-1:0]      matched_total;

	nearest_match_tracker tracker;
	bit          cmd_gaps_on = 1;
	bit          res_gaps_on = 1;
	int unsigned items_sent = 0;

	nearest_timestamp_matcher_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.command(command),
		.time_us(time_us),
		.time_present(time_present),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.match_found(match_found),
		.match_index(match_index),
		.matched_total(matched_total)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#60000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic int pick_gap(bit on);
		int r;
		r = $urandom_range(0, 99);
		if (!on || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [TB_TIME_BITS-1:0] rand_time();
		return {16'($urandom_range(0, 65535)), 32'($urandom())};
	endfunction

	// result side back-pressure
	initial begin
		int r;
		int n;
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			r = $urandom_range(0, 99);
			if (!res_gaps_on || r < 65) begin
				res_stall <= 1'b0;
			end else begin
				n = (r < 94) ? $urandom_range(1, 3) : $urandom_range(8, 40);
				res_stall <= 1'b1;
				repeat (n - 1) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			tracker.check_answer(match_found, match_index, matched_total);
	end

	task automatic send_cmd(ntm_pkg::cmd_t c, logic [TB_TIME_BITS-1:0] t, logic p);
		int gap;
		gap = pick_gap(cmd_gaps_on);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		command <= c;
		time_us <= t;
		time_present <= p;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		tracker.note_command(c, t, p);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic apb_write(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= d;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apb_check(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= a;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== want) begin
			$display("%0t: register at %0d expected %0h actual %0h", $time, a, want, prdata);
			tracker.errors++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_limits(logic [DIFF_W-1:0] d, logic en);
		apb_write(ADDR_DIFF, DATA_W'(d));
		apb_write(ADDR_LIMIT_EN, DATA_W'(en));
		tracker.take_limits(d, en);
		apb_check(ADDR_DIFF, DATA_W'(d));
		apb_check(ADDR_LIMIT_EN, DATA_W'(en));
	endtask

	// Let every pending query come back, then give the last table command time to land.
	task automatic drain();
		cmd_valid <= 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	task automatic run_random(int unsigned n);
		int unsigned first;
		int unsigned m;
		int unsigned qn;
		int unsigned k;
		int unsigned cap;
		logic [TB_TIME_BITS-1:0] base;
		logic [TB_TIME_BITS-1:0] t;
		logic [TB_TIME_BITS-1:0] qt;
		logic [TB_TIME_BITS-1:0] span;
		first = items_sent;
		while (items_sent - first < n) begin
			cmd_gaps_on = ($urandom_range(0, 3) != 0);
			res_gaps_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 9) < 7) begin
				// sorted reference stream, then queries mostly moving forward through it
				m = $urandom_range(1, 40);
				cap = ($urandom_range(0, 3) == 0) ? 40000 : 3000;
				base = ($urandom_range(0, 3) == 0) ? rand_time()
					: TB_TIME_BITS'($urandom_range(0, 1000000));
				if (base > TIME_TOP - 48'd4000000)
					base = TIME_TOP - 48'd4000000;
				send_cmd(ntm_pkg::CMD_CLEAR, rand_time(), 1'($urandom_range(0, 1)));
				send_cmd(ntm_pkg::CMD_BEGIN, rand_time(), 1'($urandom_range(0, 1)));
				t = base;
				for (k = 0; k < m; k++) begin
					if (k != 0)
						t += TB_TIME_BITS'($urandom_range(0, cap));
					send_cmd(ntm_pkg::CMD_APPEND, t, $urandom_range(0, 99) < 85);
				end
				span = t - base;
				qn = $urandom_range(1, m / 4 + 2);
				qt = (base > 48'd2000) ? base - TB_TIME_BITS'($urandom_range(0, 2000)) : base;
				for (k = 0; k < qn; k++) begin
					if ($urandom_range(0, 9) == 0)
						send_cmd(ntm_pkg::CMD_BEGIN, rand_time(), 1'($urandom_range(0, 1)));
					if ($urandom_range(0, 9) == 0) begin
						send_cmd(ntm_pkg::CMD_QUERY,
							base + TB_TIME_BITS'($urandom_range(0, 32'(span) + cap)),
							1'($urandom_range(0, 1)));
					end else begin
						qt += TB_TIME_BITS'($urandom_range(0, 32'(span) / qn + cap));
						send_cmd(ntm_pkg::CMD_QUERY, qt, 1'($urandom_range(0, 1)));
					end
				end
			end else begin
				repeat ($urandom_range(1, 6))
					send_cmd(ntm_pkg::cmd_t'(2'($urandom_range(0, 3))), rand_time(),
						1'($urandom_range(0, 1)));
			end
		end
	endtask

	initial begin
		tracker = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd_valid = 1'b0;
		command = ntm_pkg::CMD_CLEAR;
		time_us = '0;
		time_present = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty table
		send_cmd(ntm_pkg::CMD_QUERY, 48'd0, 1'b0);
		send_cmd(ntm_pkg::CMD_APPEND, 48'd0, 1'b1);
		send_cmd(ntm_pkg::CMD_APPEND, 48'd5000, 1'b0);
		send_cmd(ntm_pkg::CMD_APPEND, 48'd10000, 1'b1);
		send_cmd(ntm_pkg::CMD_APPEND, 48'd20000, 1'b1);
		send_cmd(ntm_pkg::CMD_APPEND, 48'd30000, 1'b1);
		send_cmd(ntm_pkg::CMD_BEGIN, TIME_TOP, 1'b1);
		// equal distance to two entries: earlier one wins
		send_cmd(ntm_pkg::CMD_QUERY, 48'd15000, 1'b0);
		send_cmd(ntm_pkg::CMD_QUERY, 48'd4999, 1'b1);
		// one past the limit, then exactly at it
		send_cmd(ntm_pkg::CMD_QUERY, 48'd40001, 1'b0);
		send_cmd(ntm_pkg::CMD_QUERY, 48'd40000, 1'b0);
		send_cmd(ntm_pkg::CMD_APPEND, TIME_TOP, 1'b1);
		send_cmd(ntm_pkg::CMD_QUERY, TIME_TOP, 1'b1);
		send_cmd(ntm_pkg::CMD_QUERY, 48'd0, 1'b0);
		// clear keeps the pass count
		send_cmd(ntm_pkg::CMD_CLEAR, 48'd0, 1'b0);
		send_cmd(ntm_pkg::CMD_QUERY, 48'd100, 1'b0);
		send_cmd(ntm_pkg::CMD_APPEND, 48'd50, 1'b0);
		send_cmd(ntm_pkg::CMD_QUERY, 48'd50, 1'b0);
		// out-of-order table
		send_cmd(ntm_pkg::CMD_APPEND, 48'd60, 1'b1);
		send_cmd(ntm_pkg::CMD_APPEND, 48'd10, 1'b1);
		send_cmd(ntm_pkg::CMD_QUERY, 48'd10, 1'b0);
		send_cmd(ntm_pkg::CMD_BEGIN, 48'd0, 1'b0);
		send_cmd(ntm_pkg::CMD_QUERY, 48'd61, 1'b1);

		run_random(300);
		drain();
		set_limits('1, 1'b1);
		run_random(300);
		drain();
		set_limits('0, 1'b1);
		run_random(300);
		drain();
		set_limits(DIFF_W'($urandom()), 1'b0);
		run_random(300);
		drain();
		set_limits(DIFF_W'($urandom_range(1, 3000)), 1'b1);
		run_random(300);
		drain();

		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
